// File: design/fpdiv_pkg.sv
package fpdiv_pkg;
  localparam int unsigned QuoBits = 25;
  localparam int unsigned SigBits = 24;
  localparam int unsigned ExpBits = 10;
  localparam int unsigned StepsPerStage = 5;
  localparam int unsigned NumStages = QuoBits / StepsPerStage;
  localparam logic signed [ExpBits-1:0] ExpBias = 10'sd127;
  localparam logic signed [ExpBits-1:0] ExpMaxN = 10'sd254;
  localparam logic [30:0] InfMag = 31'h7F80_0000;

  typedef struct packed {
    logic                      sign;
    logic signed [ExpBits-1:0] expo;
    logic [SigBits:0]          rem;
    logic [SigBits-1:0]        dvs;
    logic [QuoBits-1:0]        quo;
  } div_stage_t;
endpackage

// File: design/fp32_divider_unit.sv
// Single-precision divider, fully pipelined.
// Input channel s_axis: tdata = {divisor, dividend}, dividend in bits 31:0.
// Output channel m_axis: tdata = quotient word, tuser = is_normal flag.
// One item enters per cycle while s_axis_tready_o is high; an item passes through the
// unpack register, five registers of five restoring quotient steps each, and the round/pack
// output register before m_axis_tvalid_o; it lands in the unpack register at its accepting edge.
// Throughput is one item per clock while m_axis_tready_i stays high.
// A stage advances when it is empty or the stage after it advances; when the
// receiver stalls, full stages hold and s_axis_tready_o drops once every stage
// is full, so nothing is lost or repeated. Bubbles are squeezed out: a stage
// whose valid bit is clear accepts new data even during a stall.
// Reset (rst_ni low, asynchronous) clears all valid bits; payload is not reset.
// NaN, infinity, zero and subnormal inputs get no special handling.
module fp32_divider_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // [31:0] dividend, [63:32] divisor
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] quotient
  output logic        m_axis_tuser_o    // [0] is_normal
);
  localparam int unsigned NS = fpdiv_pkg::NumStages;
  localparam int unsigned SB = fpdiv_pkg::SigBits;
  localparam int unsigned QB = fpdiv_pkg::QuoBits;
  localparam int unsigned EB = fpdiv_pkg::ExpBits;

  // stage 0 is unpack, 1..NS the division stages
  fpdiv_pkg::div_stage_t st_q [NS+1];
  fpdiv_pkg::div_stage_t st_d [NS+1];
  fpdiv_pkg::div_stage_t unp_d;
  logic [NS+1:0] vld_q;
  logic [NS+1:0] adv;
  logic [31:0] res_q, res_d;
  logic        nrm_q, nrm_d;

  // advance from the output backward
  always_comb begin
    adv[NS+1] = !vld_q[NS+1] || m_axis_tready_i;
    for (int k = NS; k >= 0; k--) adv[k] = !vld_q[k] || adv[k+1];
  end
  assign s_axis_tready_o = adv[0];
  assign m_axis_tvalid_o = vld_q[NS+1];
  assign m_axis_tdata_o  = res_q;
  assign m_axis_tuser_o  = nrm_q;

  // unpack and pre-normalize
  always_comb begin
    logic [31:0] a, b;
    logic [SB-1:0] x, y;
    logic signed [EB-1:0] e;
    a = s_axis_tdata_i[31:0];
    b = s_axis_tdata_i[63:32];
    x = {1'b1, a[22:0]};
    y = {1'b1, b[22:0]};
    e = $signed({2'b00, a[30:23]}) - $signed({2'b00, b[30:23]}) + fpdiv_pkg::ExpBias;
    unp_d.sign = a[31] ^ b[31];
    unp_d.dvs  = y;
    unp_d.quo  = '0;
    if (x < y) begin
      unp_d.rem  = {x, 1'b0};
      unp_d.expo = e - EB'(1);
    end else begin
      unp_d.rem  = {1'b0, x};
      unp_d.expo = e;
    end
  end

  // restoring steps, StepsPerStage per stage
  always_comb begin
    st_d[0] = unp_d;
    for (int s = 1; s <= NS; s++) begin
      logic [SB:0] r;
      logic [QB-1:0] q;
      r = st_q[s-1].rem;
      q = st_q[s-1].quo;
      for (int i = 0; i < fpdiv_pkg::StepsPerStage; i++) begin
        q = {q[QB-2:0], 1'b0};
        if (r >= {1'b0, st_q[s-1].dvs}) begin
          r = r - {1'b0, st_q[s-1].dvs};
          q[0] = 1'b1;
        end
        r = {r[SB-1:0], 1'b0};
      end
      st_d[s] = st_q[s-1];
      st_d[s].rem = r;
      st_d[s].quo = q;
    end
  end

  // round and pack
  always_comb begin
    logic signed [EB-1:0] e;
    logic [QB-1:0] q, qs, mask;
    logic sticky;
    logic [SB-1:0] rr;
    logic [30:0] mag;
    logic [4:0] sh;
    logic signed [EB-1:0] shs;
    e = st_q[NS].expo;
    q = st_q[NS].quo;
    sticky = |st_q[NS].rem;
    shs = EB'(1) - e;
    sh = (shs > EB'(QB)) ? 5'(QB) : shs[4:0];
    mask = (QB'(1) << sh) - QB'(1);
    qs = q >> sh;
    if (e >= $signed(EB'(1)) && e <= fpdiv_pkg::ExpMaxN) begin
      rr = q[QB-1:1] + SB'(q[0] & (sticky | q[1]));
      mag = {e[7:0], 23'd0} + {8'd0, rr[22:0]} + (31'(rr[23]) << 23) - 31'(32'h0080_0000);
    end else if (e > fpdiv_pkg::ExpMaxN) begin
      rr = '0;
      mag = fpdiv_pkg::InfMag;
    end else begin
      rr = qs[QB-1:1] + SB'(qs[0] & (sticky | (|(q & mask)) | qs[1]));
      mag = {7'd0, rr};
    end
    res_d = {st_q[NS].sign, mag};
    nrm_d = (mag[30:23] != 8'hFF) && (mag[30:23] != 8'h00);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= s_axis_tvalid_i;
      for (int k = 1; k <= NS + 1; k++) begin
        if (adv[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k <= NS; k++) begin
      if (adv[k]) st_q[k] <= st_d[k];
    end
    if (adv[NS+1]) begin
      res_q <= res_d;
      nrm_q <= nrm_d;
    end
  end
endmodule

// File: tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] divisor;
    logic [31:0] dividend;
  } operands_t;

  typedef struct packed {
    logic [31:0] quotient;
    logic        is_normal;
  } quotient_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [31:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;

  fp32_divider_unit uut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .m_axis_tuser_o
  );

  operands_t pending_ops[$];
  quotient_t expected_quos[$];
  int        gap_pct;
  int        stall_pct;
  bit        hold_rx;
  int        hold_cycles;
  int        n_errors;
  int        n_checked;
  int        n_sent;

  // restoring division with round to nearest even, as the hardware does it
  function automatic quotient_t divide_fp32(operands_t op);
    quotient_t        res;
    logic [31:0]      a;
    logic [31:0]      b;
    logic [25:0]      x;
    logic [25:0]      y;
    logic [24:0]      q;
    logic [24:0]      qs;
    logic             sticky;
    logic [31:0]      r;
    int               e;
    int               sh;
    a = op.dividend;
    b = op.divisor;
    x = {2'b0, 1'b1, a[22:0]};
    y = {2'b0, 1'b1, b[22:0]};
    e = int'(a[30:23]) - int'(b[30:23]) + 127;
    q = '0;
    if (x < y) begin
      x = x << 1;
      e = e - 1;
    end
    for (int i = 0; i < 25; i++) begin
      q = q << 1;
      if (x >= y) begin
        x = x - y;
        q[0] = 1'b1;
      end
      x = x << 1;
    end
    sticky = (x != 0);
    if (e >= 1 && e <= 254) begin
      r = 32'(q >> 1) + 32'(q[0] & (sticky | q[1]));
      r = (32'(e) << 23) + (r - 32'h0080_0000);
    end else if (e > 254) begin
      r = 32'h7F80_0000;
    end else begin
      sh = 1 - e;
      if (sh > 25) sh = 25;
      if ((q & ((25'd1 << sh) - 25'd1)) != 0) sticky = 1'b1;
      qs = (sh >= 25) ? 25'd0 : (q >> sh);
      r = 32'(qs >> 1) + 32'(qs[0] & (sticky | qs[1]));
    end
    r[31] = r[31] | (a[31] ^ b[31]);
    res.quotient = r;
    res.is_normal = (r[30:23] != 8'hFF) && (r[30:23] != 8'h00);
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    n_errors++;
  endtask

  function automatic logic [31:0] rand_float(int emin, int emax);
    return {1'($urandom), 8'($urandom_range(emax, emin)), 23'($urandom)};
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        expected_quos.push_back(divide_fp32(operands_t'(s_axis_tdata_i)));
        n_sent++;
      end
      if ((!s_axis_tvalid_i || s_axis_tready_o)) begin
        if (pending_ops.size() > 0 && $urandom_range(99) >= gap_pct) begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= pending_ops.pop_front();
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (expected_quos.size() == 0) begin
          report_mismatch("unexpected item", m_axis_tdata_o, '0);
        end else begin
          quotient_t want;
          want = expected_quos.pop_front();
          if (m_axis_tdata_o !== want.quotient)
            report_mismatch("quotient", m_axis_tdata_o, want.quotient);
          if (m_axis_tuser_o !== want.is_normal)
            report_mismatch("is_normal", 32'(m_axis_tuser_o), 32'(want.is_normal));
          n_checked++;
        end
      end
      m_axis_tready_i <= !hold_rx && ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic push_pair(logic [31:0] a, logic [31:0] b);
    pending_ops.push_back('{divisor: b, dividend: a});
  endtask

  task automatic wait_drained();
    wait (pending_ops.size() == 0 && !s_axis_tvalid_i && expected_quos.size() == 0);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic fill_random(int count);
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(5))
        0: push_pair($urandom, $urandom);
        1: push_pair(rand_float(0, 20), rand_float(100, 255));
        2: push_pair(rand_float(200, 255), rand_float(0, 60));
        3: push_pair(rand_float(110, 145), rand_float(110, 145));
        4: push_pair(rand_float(100, 160), {1'($urandom), 8'($urandom_range(140, 100)),
                                            23'($urandom_range(15))});
        default: push_pair(rand_float(0, 130), rand_float(120, 255));
      endcase
    end
  endtask

  initial begin
    n_errors = 0;
    n_checked = 0;
    n_sent = 0;
    gap_pct = 0;
    stall_pct = 0;
    hold_rx = 1'b0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, exact, overflow, rounding carry, underflow, clamped shift
    push_pair(32'h3F80_0000, 32'h3F80_0000);
    push_pair(32'h4040_0000, 32'h3F80_0000);
    push_pair(32'h3F80_0000, 32'h4040_0000);
    push_pair(32'hBF80_0000, 32'h4040_0000);
    push_pair(32'h3F80_0000, 32'hC040_0000);
    push_pair(32'hBF80_0000, 32'hBF80_0000);
    push_pair(32'h7F7F_FFFF, 32'h3F00_0000);
    push_pair(32'h7F7F_FFFF, 32'h3F7F_FFFF);
    push_pair(32'hFFFF_FFFF, 32'h0000_0000);
    push_pair(32'h0000_0000, 32'hFFFF_FFFF);
    push_pair(32'h0000_0000, 32'h0000_0000);
    push_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_pair(32'h0080_0000, 32'h4000_0000);
    push_pair(32'h0080_0000, 32'h3F80_0001);
    push_pair(32'h0080_0000, 32'h4B00_0000);
    push_pair(32'h0080_0000, 32'h4D00_0000);
    push_pair(32'h0000_0001, 32'h7F00_0000);
    push_pair(32'h00FF_FFFF, 32'h3F80_0001);
    push_pair(32'h3FFF_FFFF, 32'h3F80_0001);
    push_pair(32'h7F00_0000, 32'h3F7F_FFFF);
    push_pair(32'h5555_5555, 32'hAAAA_AAAA);
    push_pair(32'hAAAA_AAAA, 32'h5555_5555);
    wait_drained();

    // long receiver hold while the sender keeps offering
    hold_rx = 1'b1;
    fill_random(40);
    hold_cycles = 0;
    while (hold_cycles < 200) begin
      @(posedge clk_i);
      hold_cycles++;
    end
    hold_rx = 1'b0;
    wait_drained();

    gap_pct = 0;  stall_pct = 0;  fill_random(400); wait_drained();
    gap_pct = 72; stall_pct = 0;  fill_random(300); wait_drained();
    gap_pct = 0;  stall_pct = 72; fill_random(300); wait_drained();
    gap_pct = 10; stall_pct = 10; fill_random(300); wait_drained();
    gap_pct = 0;  stall_pct = 0;  fill_random(290); wait_drained();
    repeat (20) @(posedge clk_i);

    $display("covered %0d operand pairs: exact, overflow, underflow, sign mixes,", n_sent);
    $display("  rounding carries, with idle and stall phases and a long output hold");
    if (n_errors == 0 && expected_quos.size() == 0) begin
      $display("[fp32_divider_unit] OK");
    end else begin
      $display("[fp32_divider_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("[fp32_divider_unit] ERROR");
    $finish;
  end
endmodule

// File: files.f
design/fpdiv_pkg.sv
design/fp32_divider_unit.sv
tb/testbench.sv
